@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off during reset.
`define SBCF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sbcf assertion failed");

// Antecedent implies consequent on the following edge.
`define SBCF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbcf assertion failed");

`endif

@@ sv/sbcf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Servo bus command framer package
// Action codes, command codes, frame constants and the frame descriptor.
// ----------------------------------------------------------------------------
package sbcf_pkg;

   localparam int FRAME_MAX = 10;
   localparam int BODY_MAX  = 7;

   typedef enum logic [2:0] {
      ACT_MOVE_TIME     = 3'd0,
      ACT_ID_WRITE      = 3'd1,
      ACT_OFFSET_ADJUST = 3'd2,
      ACT_OFFSET_SAVE   = 3'd3,
      ACT_POS_READ      = 3'd4,
      ACT_VIN_READ      = 3'd5,
      ACT_OFFSET_READ   = 3'd6
   } action_type;

   localparam logic [7:0] FRAME_HEADER      = 8'h55;
   localparam logic [7:0] BROADCAST_ID      = 8'd254;
   localparam logic [9:0] POS_MAX           = 10'd1000;
   localparam logic [7:0] CMD_MOVE_TIME     = 8'd1;
   localparam logic [7:0] CMD_ID_WRITE      = 8'd13;
   localparam logic [7:0] CMD_OFFSET_ADJUST = 8'd17;
   localparam logic [7:0] CMD_OFFSET_SAVE   = 8'd18;
   localparam logic [7:0] CMD_OFFSET_READ   = 8'd19;
   localparam logic [7:0] CMD_VIN_READ      = 8'd27;
   localparam logic [7:0] CMD_POS_READ      = 8'd28;

   localparam logic [2:0] BODY_LEN_SHORT = 3'd3;
   localparam logic [2:0] BODY_LEN_PARAM = 3'd4;
   localparam logic [2:0] BODY_LEN_MOVE  = 3'd7;

   // Complete frame, byte 0 sent first; last_idx is the checksum position.
   typedef struct packed {
      logic [FRAME_MAX-1:0][7:0] bytes;
      logic [3:0]                last_idx;
   } frame_type;

endpackage
`default_nettype wire

@@ sv/sbcf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Servo bus command framer front end
// Accepts command items, builds the frame with its checksum, pushes it unless the action code is unknown.
// ----------------------------------------------------------------------------
module sbcf_front (
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [55:0]        req_tdata,
   input  wire logic               q_full,
   output logic                    q_push,
   output sbcf_pkg::frame_type     q_frame
);
   import sbcf_pkg::*;

   logic [2:0]            action;
   logic [7:0]            servo_id;
   logic [15:0]           position;
   logic [15:0]           move_time;
   logic [7:0]            angle_offset;
   logic [9:0]            pos_clamp;
   logic [BODY_MAX-1:0][7:0] body;
   logic [2:0]            body_len;
   logic                  act_ok;
   logic [7:0]            sum;
   logic [7:0]            chk;

   assign action       = req_tdata[2:0];
   assign servo_id     = req_tdata[10:3];
   assign position     = req_tdata[26:11];
   assign move_time    = req_tdata[42:27];
   assign angle_offset = req_tdata[50:43];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && act_ok;

   always_comb begin
      if (position[15]) begin
         pos_clamp = '0;
      end else if (position[14:0] > {5'd0, POS_MAX}) begin
         pos_clamp = POS_MAX;
      end else begin
         pos_clamp = position[9:0];
      end
   end

   always_comb begin
      body     = '0;
      body_len = BODY_LEN_SHORT;
      act_ok   = 1'b1;
      body[0]  = servo_id;
      body[1]  = {5'd0, BODY_LEN_SHORT};
      case (action)
         ACT_MOVE_TIME: begin
            body_len = BODY_LEN_MOVE;
            body[1]  = {5'd0, BODY_LEN_MOVE};
            body[2]  = CMD_MOVE_TIME;
            body[3]  = pos_clamp[7:0];
            body[4]  = {6'd0, pos_clamp[9:8]};
            body[5]  = move_time[7:0];
            body[6]  = move_time[15:8];
         end
         ACT_ID_WRITE: begin
            body_len = BODY_LEN_PARAM;
            body[0]  = BROADCAST_ID;
            body[1]  = {5'd0, BODY_LEN_PARAM};
            body[2]  = CMD_ID_WRITE;
            body[3]  = servo_id;
         end
         ACT_OFFSET_ADJUST: begin
            body_len = BODY_LEN_PARAM;
            body[1]  = {5'd0, BODY_LEN_PARAM};
            body[2]  = CMD_OFFSET_ADJUST;
            body[3]  = angle_offset;
         end
         ACT_OFFSET_SAVE:   body[2] = CMD_OFFSET_SAVE;
         ACT_POS_READ:      body[2] = CMD_POS_READ;
         ACT_VIN_READ:      body[2] = CMD_VIN_READ;
         ACT_OFFSET_READ:   body[2] = CMD_OFFSET_READ;
         default:           act_ok  = 1'b0;
      endcase
   end

   // unused body bytes are zero, so they drop out of the sum
   always_comb begin
      sum = '0;
      for (int i = 0; i < BODY_MAX; i++) begin
         sum = sum + body[i];
      end
   end

   assign chk = ~sum;

   always_comb begin
      q_frame.bytes    = '0;
      q_frame.bytes[0] = FRAME_HEADER;
      q_frame.bytes[1] = FRAME_HEADER;
      for (int i = 0; i < BODY_MAX; i++) begin
         q_frame.bytes[i+2] = body[i];
      end
      case (body_len)
         BODY_LEN_SHORT: q_frame.bytes[5] = chk;
         BODY_LEN_PARAM: q_frame.bytes[6] = chk;
         BODY_LEN_MOVE:  q_frame.bytes[9] = chk;
         default:        q_frame.bytes[9] = chk;
      endcase
      q_frame.last_idx = {1'b0, body_len} + 4'd2;
   end

endmodule
`default_nettype wire

@@ sv/sbcf_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Servo bus command framer frame queue
// Small FIFO of built frames between the front end and the byte sender.
// ----------------------------------------------------------------------------
module sbcf_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sbcf_pkg::frame_type push_frame,
   input  wire logic                pop,
   output logic                     full,
   output logic                     q_valid,
   output sbcf_pkg::frame_type      head
);
   import sbcf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type         mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_frame;
      end
   end

endmodule
`default_nettype wire

@@ sv/sbcf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Servo bus command framer byte sender
// Walks the head frame one byte per cycle into the output register while rsp_tready allows.
// ----------------------------------------------------------------------------
module sbcf_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire sbcf_pkg::frame_type head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);
   import sbcf_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_last;

   assign load    = q_valid && (!valid_ff || rsp_tready);
   assign at_last = (idx_ff == head.last_idx);
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = head.bytes[idx_ff];
         last_in  = at_last;
         idx_in   = at_last ? '0 : idx_ff + 4'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

@@ sv/servo_bus_command_framer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Servo bus command framer
// Turns servo commands into serial bus frames with header and checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item per handshake. rsp_* carries the frame
//   one byte per item, rsp_tlast high on the checksum byte.
//   Frames are 10 bytes for move_time, 7 for id_write and offset_adjust,
//   6 for the save and read requests; action code 7 yields nothing.
//   With the queue empty, a taken command is written into the queue and
//   its first byte is then loaded into the output register.
//   Throughput: one byte per cycle while rsp_tready does not stall it;
//   frames follow each other without a gap.
//   The front end builds whole frames into a queue of QUEUE_DEPTH entries
//   and keeps taking commands until that queue is full, so a new command
//   is taken while earlier frames are still being sent.
//   When rsp_tready is low the output byte holds and the queue fills;
//   req_tready drops once it is full.
//   Reset empties the queue and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_bus_command_framer_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[2:0], servo_id[10:3], position[26:11], move_time[42:27],
   // angle_offset[50:43], zero pad[55:51]
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tx_byte[7:0]
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);
   import sbcf_pkg::*;

   frame_type push_frame;
   frame_type head;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_valid;

   sbcf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_frame    (push_frame)
   );

   sbcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (push_frame),
      .pop        (q_pop),
      .full       (q_full),
      .q_valid    (q_valid),
      .head       (head)
   );

   sbcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `SBCF_ASSERT(a_pop_nonempty, clock, reset, !q_pop || q_valid)
   `SBCF_ASSERT(a_bad_action_dropped, clock, reset, !(q_push && (req_tdata[2:0] > ACT_OFFSET_READ)))
   `SBCF_ASSERT_NEXT(a_pop_shows_last, clock, reset, q_pop, rsp_tvalid && rsp_tlast)

endmodule
`default_nettype wire

@@ sim/servo_bus_command_framer_checker.sv @@
// ----------------------------------------------------------------------------
// Servo bus command framer checker
// Watches both streams, builds the expected frame for every accepted known command
// and compares each transmitted byte and its end-of-frame flag in order.
// ----------------------------------------------------------------------------
module sbcf_frame_checker
   import sbcf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        end_of_test,
   output int               fail_count,
   output int               pending,
   output int               cmd_count,
   output int               unknown_count,
   output int               frame_count,
   output int               byte_count
);

   typedef struct {
      logic [7:0] tx_byte;
      logic       last_byte;
   } frame_byte_type;

   frame_byte_type frame_bytes_due[$];
   bit             leftovers_checked;

   initial begin
      fail_count        = 0;
      pending           = 0;
      cmd_count         = 0;
      unknown_count     = 0;
      frame_count       = 0;
      byte_count        = 0;
      leftovers_checked = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] frame mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic void push_frame_byte(input logic [7:0] value, input logic last);
      frame_byte_type fb;
      fb.tx_byte   = value;
      fb.last_byte = last;
      frame_bytes_due.push_back(fb);
   endfunction

   // Expected frame for one command: header pair, body, inverted checksum.
   function automatic void predict_frame(input logic [55:0] cmd);
      logic [2:0]  act;
      logic [7:0]  id;
      int          pos;
      logic [15:0] dur;
      logic [7:0]  ang;
      logic [7:0]  body [BODY_MAX];
      int          len;
      logic [7:0]  sum;
      act = cmd[2:0];
      id  = cmd[10:3];
      pos = $signed(cmd[26:11]);
      dur = cmd[42:27];
      ang = cmd[50:43];
      len = 0;
      case (act)
         ACT_MOVE_TIME: begin
            if (pos < 0) pos = 0;
            else if (pos > int'(POS_MAX)) pos = int'(POS_MAX);
            body[0] = id;
            body[1] = 8'(BODY_LEN_MOVE);
            body[2] = CMD_MOVE_TIME;
            body[3] = pos[7:0];
            body[4] = pos[15:8];
            body[5] = dur[7:0];
            body[6] = dur[15:8];
            len = int'(BODY_LEN_MOVE);
         end
         ACT_ID_WRITE: begin
            body[0] = BROADCAST_ID;
            body[1] = 8'(BODY_LEN_PARAM);
            body[2] = CMD_ID_WRITE;
            body[3] = id;
            len = int'(BODY_LEN_PARAM);
         end
         ACT_OFFSET_ADJUST: begin
            body[0] = id;
            body[1] = 8'(BODY_LEN_PARAM);
            body[2] = CMD_OFFSET_ADJUST;
            body[3] = ang;
            len = int'(BODY_LEN_PARAM);
         end
         ACT_OFFSET_SAVE, ACT_POS_READ, ACT_VIN_READ, ACT_OFFSET_READ: begin
            body[0] = id;
            body[1] = 8'(BODY_LEN_SHORT);
            case (act)
               ACT_OFFSET_SAVE: body[2] = CMD_OFFSET_SAVE;
               ACT_POS_READ:    body[2] = CMD_POS_READ;
               ACT_VIN_READ:    body[2] = CMD_VIN_READ;
               default:         body[2] = CMD_OFFSET_READ;
            endcase
            len = int'(BODY_LEN_SHORT);
         end
         default: len = 0;
      endcase
      if (len == 0) begin
         unknown_count++;
         return;
      end
      frame_count++;
      push_frame_byte(FRAME_HEADER, 1'b0);
      push_frame_byte(FRAME_HEADER, 1'b0);
      sum = 8'd0;
      for (int i = 0; i < len; i++) begin
         sum += body[i];
         push_frame_byte(body[i], 1'b0);
      end
      push_frame_byte(~sum, 1'b1);
   endfunction

   always @(posedge clock) begin
      frame_byte_type due;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            cmd_count++;
            predict_frame(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            byte_count++;
            if (frame_bytes_due.size() == 0) begin
               report_mismatch($sformatf("byte %02h with no frame pending", rsp_tdata));
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_tdata !== due.tx_byte)
                  report_mismatch($sformatf("tx_byte %02h, wanted %02h",
                                            rsp_tdata, due.tx_byte));
               if (rsp_tlast !== due.last_byte)
                  report_mismatch($sformatf("last_byte %b, wanted %b on byte %02h",
                                            rsp_tlast, due.last_byte, due.tx_byte));
            end
         end
         if (end_of_test && !leftovers_checked) begin
            leftovers_checked = 1;
            if (frame_bytes_due.size() != 0)
               report_mismatch($sformatf("%0d frame bytes never sent",
                                         frame_bytes_due.size()));
         end
      end
      pending = frame_bytes_due.size();
   end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Servo bus command framer testbench
// Drives directed and random servo commands with bursty timing against a
// stalling byte receiver; the frame checker predicts and compares each byte.
// ----------------------------------------------------------------------------
module tb_top;
   import sbcf_pkg::*;

   localparam logic [2:0] ACT_UNKNOWN     = 3'd7;
   localparam int         RANDOM_ITEMS    = 415;
   localparam int         HOLD_OFF_CYCLES = 80;
   localparam int         HOLD_OFF_ITEMS  = 20;
   localparam int         SETTLE_CYCLES   = 20;
   localparam int         CYCLE_LIMIT     = 300000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   logic        hold_off_armed = 1'b0;
   logic        end_of_test    = 1'b0;
   int          random_sent    = 0;
   int          cycle_count    = 0;

   int fail_count, pending, cmd_count, unknown_count, frame_count, byte_count;

   always #1 clock = ~clock;

   servo_bus_command_framer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sbcf_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .end_of_test   (end_of_test),
      .fail_count    (fail_count),
      .pending       (pending),
      .cmd_count     (cmd_count),
      .unknown_count (unknown_count),
      .frame_count   (frame_count),
      .byte_count    (byte_count)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles, %0d bytes still due", cycle_count, pending);
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [55:0] pack_cmd(input logic [2:0] act, input logic [7:0] id,
                                            input logic [15:0] pos, input logic [15:0] dur,
                                            input logic [7:0] ang);
      return {5'd0, ang, dur, pos, id, act};
   endfunction

   function automatic logic [55:0] random_cmd();
      logic [2:0]  act;
      logic [15:0] pos;
      act = ($urandom_range(0, 99) < 5) ? ACT_UNKNOWN : 3'($urandom_range(0, 6));
      case ($urandom_range(0, 3))
         0:       pos = 16'($urandom_range(0, 1000));
         1:       pos = 16'($urandom_range(1001, 32767));
         2:       pos = 16'($urandom_range(32768, 65535));
         default: pos = 16'($urandom);
      endcase
      return pack_cmd(act, 8'($urandom), pos, 16'($urandom), 8'($urandom));
   endfunction

   // Holds the item until taken; leaves tvalid high for a following item.
   task automatic send_item(input logic [55:0] cmd);
      req_tdata  = cmd;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_random();
      logic [55:0] cmd;
      cmd = random_cmd();
      send_item(cmd);
      if (cmd[2:0] != ACT_UNKNOWN) random_sent++;
   endtask

   task automatic idle_gap(input int cycles);
      req_tvalid = 1'b0;
      repeat (cycles) begin
         req_tdata = 56'({$urandom, $urandom});
         @(negedge clock);
      end
   endtask

   // Receiver: runs of random stall modes, plus one long hold-off on request.
   initial begin
      int mode;
      int run;
      bit hold_taken;
      hold_taken = 0;
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(8, 40);
         repeat (run) begin
            @(negedge clock);
            if (hold_off_armed && !hold_taken) begin
               hold_taken = 1;
               rsp_tready = 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end
            case (mode)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = 1'($urandom_range(0, 1));
               2:       rsp_tready = ($urandom_range(0, 2) == 0);
               default: rsp_tready = ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   initial begin
      logic [55:0] directed [$];
      bit          drained;
      drained = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // position clamp edges, both move_time byte extremes, id 0/254/255
      directed.push_back(pack_cmd(ACT_MOVE_TIME, 8'd0, 16'd0, 16'd0, 8'h00));
      directed.push_back(pack_cmd(ACT_MOVE_TIME, 8'd254, 16'd1000, 16'hFFFF, 8'hFF));
      directed.push_back(pack_cmd(ACT_MOVE_TIME, 8'd255, 16'h8000, 16'h00FF, 8'h5A));
      directed.push_back(pack_cmd(ACT_MOVE_TIME, 8'd1, 16'h7FFF, 16'hFF00, 8'hA5));
      directed.push_back(pack_cmd(ACT_MOVE_TIME, 8'd17, 16'hFFFF, 16'h1234, 8'h80));
      directed.push_back(pack_cmd(ACT_MOVE_TIME, 8'd33, 16'd1001, 16'hABCD, 8'h7F));
      directed.push_back(pack_cmd(ACT_MOVE_TIME, 8'd128, 16'd999, 16'd1, 8'h01));
      directed.push_back(pack_cmd(ACT_ID_WRITE, 8'd0, 16'hFFFF, 16'hFFFF, 8'hFF));
      directed.push_back(pack_cmd(ACT_ID_WRITE, 8'd255, 16'd0, 16'd0, 8'h00));
      directed.push_back(pack_cmd(ACT_ID_WRITE, 8'd254, 16'h1357, 16'h2468, 8'h3C));
      directed.push_back(pack_cmd(ACT_OFFSET_ADJUST, 8'd5, 16'h8000, 16'hFFFF, 8'h80));
      directed.push_back(pack_cmd(ACT_OFFSET_ADJUST, 8'd255, 16'h7FFF, 16'd0, 8'h7F));
      directed.push_back(pack_cmd(ACT_OFFSET_ADJUST, 8'd254, 16'd0, 16'd0, 8'hFF));
      directed.push_back(pack_cmd(ACT_OFFSET_SAVE, 8'd255, 16'hFFFF, 16'hFFFF, 8'hFF));
      directed.push_back(pack_cmd(ACT_OFFSET_SAVE, 8'd0, 16'd0, 16'd0, 8'h00));
      directed.push_back(pack_cmd(ACT_POS_READ, 8'd254, 16'h4321, 16'h8765, 8'h12));
      directed.push_back(pack_cmd(ACT_VIN_READ, 8'd0, 16'hFFFF, 16'hFFFF, 8'hFF));
      directed.push_back(pack_cmd(ACT_OFFSET_READ, 8'd255, 16'd0, 16'd0, 8'h00));
      directed.push_back(pack_cmd(ACT_UNKNOWN, 8'd3, 16'd500, 16'd100, 8'h10));
      directed.push_back(pack_cmd(ACT_UNKNOWN, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      directed.push_back(pack_cmd(ACT_POS_READ, 8'd1, 16'd0, 16'd0, 8'h00));
      foreach (directed[i]) send_item(directed[i]);
      idle_gap(3);

      while (random_sent < RANDOM_ITEMS) begin
         repeat ($urandom_range(1, 12)) offer_random();
         if (random_sent >= 120 && !hold_off_armed) begin
            hold_off_armed = 1'b1;
            repeat (HOLD_OFF_ITEMS) offer_random();
         end
         if (random_sent >= 280 && !drained) begin
            drained    = 1;
            req_tvalid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
      req_tvalid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      end_of_test = 1'b1;
      @(negedge clock);

      $display("Sent %0d commands (%0d with the unknown action code), %0d frames built",
               cmd_count, unknown_count, frame_count);
      $display("Compared %0d frame bytes under bursty input and a stalling receiver",
               byte_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/sbcf_pkg.sv
sv/sbcf_front.sv
sv/sbcf_queue.sv
sv/sbcf_back.sv
sv/servo_bus_command_framer_top.sv
sim/servo_bus_command_framer_checker.sv
sim/tb_top.sv
